>>> rtl/core/wavhdr_pkg.sv
// shared constants for the riff/wave header chunk parser
`default_nettype none

package wavhdr_pkg;

    localparam int ADDR_W = 3;

    // register indexes (index = byte address / 4)
    localparam logic REG_FILE_LENGTH = 1'b0;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TOO_SMALL = 3'd1;
    localparam logic [2:0] ST_NOT_RIFF  = 3'd2;
    localparam logic [2:0] ST_NOT_WAVE  = 3'd3;
    localparam logic [2:0] ST_BAD_CHUNK = 3'd4;
    localparam logic [2:0] ST_FMT_ERR   = 3'd5;
    localparam logic [2:0] ST_NO_DATA   = 3'd6;

    // chunk tags, first byte in the top lane
    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_FACT = 32'h6661_6374;

    localparam logic [31:0] MIN_FILE   = 32'd44;
    localparam logic [31:0] FMT_BYTES  = 32'd16;
    localparam logic [7:0]  CHAR_FIRST = 8'd32;
    localparam logic [7:0]  CHAR_LAST  = 8'd126;

    // every tag byte must be printable ascii
    function automatic logic tag_ok(input logic [31:0] t);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < 4; i++)
        begin
            if (t[8*i +: 8] < CHAR_FIRST || t[8*i +: 8] > CHAR_LAST)
            begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/wave_header_chunk_parser_top.sv
// riff/wave header chunk parser: one file byte per request, one result per file
// latency: a result is valid in the cycle after its completing byte request is accepted
// throughput: one byte request per cycle; a request is held off only while a
//   result waits and result_ready is low
// reset: rst_n clears the parse state to the riff tag and file_length to zero,
//   so parsing starts without a start_req
`default_nettype none

module wave_header_chunk_parser_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // config port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [wavhdr_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [31:0]                     pwdata,
    output logic      [31:0]                     prdata,
    output logic                                 pready,
    // byte requests
    input  wire logic                            item_valid,
    output logic                                 item_ready,
    input  wire logic [7:0]                      byte_value,
    input  wire logic                            start_req,
    // results
    output logic                                 result_valid,
    input  wire logic                            result_ready,
    output logic      [2:0]                      status,
    output logic      [31:0]                     data_offset,
    output logic      [31:0]                     data_length,
    output logic      [31:0]                     sample_length,
    output logic      [15:0]                     format_tag,
    output logic      [15:0]                     channel_count,
    output logic      [31:0]                     sample_rate,
    output logic      [31:0]                     byte_rate,
    output logic      [15:0]                     block_align,
    output logic      [15:0]                     sample_bits
);
    import wavhdr_pkg::*;

    typedef enum logic [2:0] {
        PH_RIFF,
        PH_RSIZE,
        PH_WAVE,
        PH_HDR,
        PH_BODY
    } phase_t;

    // state
    logic [31:0] file_length_reg;
    phase_t      phase_reg, phase_next, phase_cur;
    logic [31:0] position_reg, position_next, pos_cur;
    logic [31:0] chunk_tag_reg, chunk_tag_next, tag_cur;
    logic [31:0] chunk_size_reg, chunk_size_next, size_cur;
    logic [31:0] body_remaining_reg, body_remaining_next, rem_cur;
    logic [4:0]  body_off_reg, body_off_next;
    logic [7:0]  fmt_reg [16];
    logic [7:0]  fmt_next [16];
    logic [7:0]  fmt_cur [16];
    logic [31:0] fact_count_reg, fact_count_next, fact_cur;
    logic        finished_reg, finished_next, fin_cur;

    // result register
    logic        result_valid_reg;
    logic [2:0]  status_reg;
    logic [31:0] data_offset_reg, data_length_reg, sample_length_reg;
    logic [7:0]  res_fmt_reg [16];

    logic        item_acc;
    logic        cfg_wr;
    logic        emit;
    logic [2:0]  st;
    logic [31:0] off_out, len_out;

    logic [31:0] tag_shift, size_shift, padded;
    logic [2:0]  hdr_rem, hdr_idx;
    logic        hdr_ge, too_far, in_body;

    assign item_ready = !result_valid_reg || result_ready;
    assign item_acc   = item_valid && item_ready;
    assign cfg_wr     = psel && penable && pwrite && (paddr[2] == REG_FILE_LENGTH);
    assign pready     = 1'b1;
    assign prdata     = (paddr[2] == REG_FILE_LENGTH) ? file_length_reg : 32'd0;

    // start_req restarts parsing with this very byte
    always_comb
    begin
        phase_cur = start_req ? PH_RIFF : phase_reg;
        pos_cur   = start_req ? 32'd0 : position_reg;
        tag_cur   = start_req ? 32'd0 : chunk_tag_reg;
        size_cur  = start_req ? 32'd0 : chunk_size_reg;
        rem_cur   = start_req ? 32'd0 : body_remaining_reg;
        fact_cur  = start_req ? 32'd0 : fact_count_reg;
        fin_cur   = start_req ? 1'b0 : finished_reg;
        for (int i = 0; i < 16; i++)
        begin
            fmt_cur[i] = start_req ? 8'd0 : fmt_reg[i];
        end
    end

    assign tag_shift  = {tag_cur[23:0], byte_value};
    assign size_shift = {byte_value, size_cur[31:8]};
    assign padded     = size_shift + {31'd0, size_shift[0]};
    assign hdr_rem    = rem_cur[2:0] - 3'd1;
    assign hdr_idx    = 3'd0 - rem_cur[2:0];
    // next header would start at pos+1: no room if pos+1+8 >= file_length
    assign hdr_ge     = ({1'b0, pos_cur} + 33'd9) >= {1'b0, file_length_reg};
    // header end + size > file_length
    assign too_far    = ({1'b0, pos_cur} + {1'b0, size_shift}) >= {1'b0, file_length_reg};
    // byte lies inside the chunk body, not the pad byte
    assign in_body    = rem_cur > {31'd0, size_cur[0]};

    always_comb
    begin
        phase_next          = phase_cur;
        position_next       = pos_cur;
        chunk_tag_next      = tag_cur;
        chunk_size_next     = size_cur;
        body_remaining_next = rem_cur;
        body_off_next       = body_off_reg;
        fact_count_next     = fact_cur;
        finished_next       = fin_cur;
        for (int i = 0; i < 16; i++)
        begin
            fmt_next[i] = fmt_cur[i];
        end
        emit    = 1'b0;
        st      = ST_OK;
        off_out = 32'd0;
        len_out = 32'd0;

        if (!fin_cur)
        begin
            position_next = pos_cur + 32'd1;
            unique case (phase_cur)
                PH_RIFF:
                begin
                    if (pos_cur == 32'd0 && file_length_reg < MIN_FILE)
                    begin
                        emit = 1'b1;
                        st   = ST_TOO_SMALL;
                    end
                    else
                    begin
                        chunk_tag_next = tag_shift;
                        if (pos_cur == 32'd3)
                        begin
                            if (tag_shift != TAG_RIFF)
                            begin
                                emit = 1'b1;
                                st   = ST_NOT_RIFF;
                            end
                            else
                            begin
                                phase_next = PH_RSIZE;
                            end
                        end
                    end
                end
                PH_RSIZE:
                begin
                    if (pos_cur == 32'd7)
                    begin
                        phase_next = PH_WAVE;
                    end
                end
                PH_WAVE:
                begin
                    chunk_tag_next = tag_shift;
                    if (pos_cur == 32'd11)
                    begin
                        if (tag_shift != TAG_WAVE)
                        begin
                            emit = 1'b1;
                            st   = ST_NOT_WAVE;
                        end
                        else if (hdr_ge)
                        begin
                            emit = 1'b1;
                            st   = ST_NO_DATA;
                        end
                        else
                        begin
                            phase_next          = PH_HDR;
                            body_remaining_next = 32'd8;
                        end
                    end
                end
                PH_HDR:
                begin
                    if (!hdr_idx[2])
                    begin
                        chunk_tag_next = tag_shift;
                    end
                    else
                    begin
                        chunk_size_next = size_shift;
                    end
                    body_remaining_next = {29'd0, hdr_rem};
                    // last header byte is always a size byte
                    if (hdr_rem == 3'd0)
                    begin
                        if (tag_cur == TAG_DATA)
                        begin
                            emit    = 1'b1;
                            st      = ST_OK;
                            off_out = pos_cur + 32'd1;
                            len_out = size_shift;
                        end
                        else if (!tag_ok(tag_cur) || too_far)
                        begin
                            emit = 1'b1;
                            st   = ST_BAD_CHUNK;
                        end
                        else if (tag_cur == TAG_FMT && size_shift < FMT_BYTES)
                        begin
                            emit = 1'b1;
                            st   = ST_FMT_ERR;
                        end
                        else
                        begin
                            if (tag_cur == TAG_FACT)
                            begin
                                fact_count_next = 32'd0;
                            end
                            if (padded == 32'd0)
                            begin
                                if (hdr_ge)
                                begin
                                    emit = 1'b1;
                                    st   = ST_NO_DATA;
                                end
                                else
                                begin
                                    body_remaining_next = 32'd8;
                                end
                            end
                            else
                            begin
                                body_remaining_next = padded;
                                body_off_next       = 5'd0;
                                phase_next          = PH_BODY;
                            end
                        end
                    end
                end
                PH_BODY:
                begin
                    if (in_body)
                    begin
                        if (tag_cur == TAG_FMT && !body_off_reg[4])
                        begin
                            fmt_next[body_off_reg[3:0]] = byte_value;
                        end
                        else if (tag_cur == TAG_FACT && body_off_reg < 5'd4)
                        begin
                            fact_count_next = fact_cur |
                                ({24'd0, byte_value} << {body_off_reg[1:0], 3'd0});
                        end
                    end
                    body_off_next       = body_off_reg[4] ? body_off_reg
                                                          : body_off_reg + 5'd1;
                    body_remaining_next = rem_cur - 32'd1;
                    if (rem_cur == 32'd1)
                    begin
                        if (hdr_ge)
                        begin
                            emit = 1'b1;
                            st   = ST_NO_DATA;
                        end
                        else
                        begin
                            phase_next          = PH_HDR;
                            body_remaining_next = 32'd8;
                        end
                    end
                end
                default:
                begin
                    finished_next = 1'b1;
                end
            endcase
            if (emit)
            begin
                finished_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            file_length_reg    <= 32'd0;
            phase_reg          <= PH_RIFF;
            position_reg       <= 32'd0;
            chunk_tag_reg      <= 32'd0;
            chunk_size_reg     <= 32'd0;
            body_remaining_reg <= 32'd0;
            body_off_reg       <= 5'd0;
            fact_count_reg     <= 32'd0;
            finished_reg       <= 1'b0;
            result_valid_reg   <= 1'b0;
            for (int i = 0; i < 16; i++)
            begin
                fmt_reg[i] <= 8'd0;
            end
        end
        else
        begin
            if (cfg_wr)
            begin
                file_length_reg <= pwdata;
            end
            if (item_acc)
            begin
                phase_reg          <= phase_next;
                position_reg       <= position_next;
                chunk_tag_reg      <= chunk_tag_next;
                chunk_size_reg     <= chunk_size_next;
                body_remaining_reg <= body_remaining_next;
                body_off_reg       <= body_off_next;
                fact_count_reg     <= fact_count_next;
                finished_reg       <= finished_next;
                for (int i = 0; i < 16; i++)
                begin
                    fmt_reg[i] <= fmt_next[i];
                end
            end
            if (item_acc && emit)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (item_acc && emit)
        begin
            status_reg        <= st;
            data_offset_reg   <= off_out;
            data_length_reg   <= len_out;
            sample_length_reg <= fact_count_next;
            for (int i = 0; i < 16; i++)
            begin
                res_fmt_reg[i] <= fmt_next[i];
            end
        end
    end

    assign result_valid  = result_valid_reg;
    assign status        = status_reg;
    assign data_offset   = data_offset_reg;
    assign data_length   = data_length_reg;
    assign sample_length = sample_length_reg;
    assign format_tag    = {res_fmt_reg[1], res_fmt_reg[0]};
    assign channel_count = {res_fmt_reg[3], res_fmt_reg[2]};
    assign sample_rate   = {res_fmt_reg[7], res_fmt_reg[6], res_fmt_reg[5], res_fmt_reg[4]};
    assign byte_rate     = {res_fmt_reg[11], res_fmt_reg[10], res_fmt_reg[9], res_fmt_reg[8]};
    assign block_align   = {res_fmt_reg[13], res_fmt_reg[12]};
    assign sample_bits   = {res_fmt_reg[15], res_fmt_reg[14]};

`ifndef SYNTHESIS
    // a new result only comes from an accepted request
    a_result_from_request: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(item_acc && emit))
        else $error("result appeared without an accepted request");

    // once a file has its result, later bytes stay silent until restart
    a_silent_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        (item_acc && finished_reg && !start_req) |-> !emit)
        else $error("second result for one file");

    // a result marks the file finished
    a_finish_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        (item_acc && emit) |=> finished_reg)
        else $error("result given but parse not finished");

    // an ok status comes only from a chunk header byte
    a_ok_from_header: assert property (@(posedge clk) disable iff (!rst_n)
        (item_acc && emit && st == ST_OK) |-> (phase_cur == PH_HDR))
        else $error("ok status outside chunk header");
`endif

endmodule

`default_nettype wire

>>> verif/wave_header_chunk_parser_checker.sv
// checker for the riff/wave header parser: predicts each file summary and compares results
module wave_header_chunk_parser_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wavhdr_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    input  logic                          pready,
    input  logic                          item_valid,
    input  logic                          item_ready,
    input  logic [7:0]                    byte_value,
    input  logic                          start_req,
    input  logic                          result_valid,
    input  logic                          result_ready,
    input  logic [2:0]                    status,
    input  logic [31:0]                   data_offset,
    input  logic [31:0]                   data_length,
    input  logic [31:0]                   sample_length,
    input  logic [15:0]                   format_tag,
    input  logic [15:0]                   channel_count,
    input  logic [31:0]                   sample_rate,
    input  logic [31:0]                   byte_rate,
    input  logic [15:0]                   block_align,
    input  logic [15:0]                   sample_bits,
    output int                            mismatch_count,
    output int                            summaries_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import wavhdr_pkg::*;

    localparam logic [ADDR_W-1:0] LEN_ADDR = {REG_FILE_LENGTH, 2'b00};

    typedef enum logic [2:0] {
        PH_RIFF_TAG,
        PH_RIFF_SIZE,
        PH_WAVE_TAG,
        PH_CHUNK_HEAD,
        PH_CHUNK_BODY
    } parse_phase_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] data_offset;
        logic [31:0] data_length;
        logic [31:0] sample_length;
        logic [15:0] format_tag;
        logic [15:0] channel_count;
        logic [31:0] sample_rate;
        logic [31:0] byte_rate;
        logic [15:0] block_align;
        logic [15:0] sample_bits;
    } wave_summary_t;

    wave_summary_t summary_queue[$];
    wave_summary_t oldest;

    logic [31:0]  file_len_q;
    logic [31:0]  position_q;
    parse_phase_t phase_q;
    logic [31:0]  tag_q;
    logic [31:0]  size_q;
    logic [31:0]  remain_q;
    logic [63:0]  fmt_lo;
    logic [63:0]  fmt_hi;
    logic [31:0]  fact_q;
    logic         parse_done;

    int mismatches;

    function automatic void restart_parser();
        position_q = '0;
        phase_q    = PH_RIFF_TAG;
        tag_q      = '0;
        size_q     = '0;
        remain_q   = '0;
        fmt_lo     = '0;
        fmt_hi     = '0;
        fact_q     = '0;
        parse_done = 1'b0;
    endfunction

    function automatic logic is_printable_tag(input logic [31:0] t);
        logic ok;
        ok = 1'b1;
        for (int lane = 0; lane < 4; lane++)
        begin
            if (t[8*lane +: 8] < 8'd32 || t[8*lane +: 8] > 8'd126)
                ok = 1'b0;
        end
        return ok;
    endfunction

    // returns 1 when no further chunk header fits in the file, else arms the next chunk header
    function automatic logic header_past_end(input logic [63:0] nxt);
        if (nxt + 64'd8 >= {32'd0, file_len_q})
            return 1'b1;
        phase_q  = PH_CHUNK_HEAD;
        remain_q = 32'd8;
        return 1'b0;
    endfunction

    function automatic void advance_parser(input logic [7:0] b, input logic first);
        logic [31:0]   pos;
        logic [63:0]   nxt;
        logic [63:0]   padded;
        logic [31:0]   padded32;
        logic [31:0]   off;
        logic [31:0]   used;
        logic          emit;
        logic [2:0]    st;
        logic [31:0]   out_off;
        logic [31:0]   out_len;
        wave_summary_t s;
        emit    = 1'b0;
        st      = ST_OK;
        out_off = '0;
        out_len = '0;
        if (first)
            restart_parser();
        if (parse_done)
            return;
        pos        = position_q;
        position_q = pos + 32'd1;
        nxt        = {32'd0, pos} + 64'd1;
        case (phase_q)
            PH_RIFF_TAG:
            begin
                if (pos == 32'd0 && file_len_q < MIN_FILE)
                begin
                    emit = 1'b1;
                    st   = ST_TOO_SMALL;
                end
                else
                begin
                    tag_q = {tag_q[23:0], b};
                    if (pos == 32'd3)
                    begin
                        if (tag_q != TAG_RIFF)
                        begin
                            emit = 1'b1;
                            st   = ST_NOT_RIFF;
                        end
                        else
                            phase_q = PH_RIFF_SIZE;
                    end
                end
            end
            PH_RIFF_SIZE:
            begin
                if (pos == 32'd7)
                    phase_q = PH_WAVE_TAG;
            end
            PH_WAVE_TAG:
            begin
                tag_q = {tag_q[23:0], b};
                if (pos == 32'd11)
                begin
                    if (tag_q != TAG_WAVE)
                    begin
                        emit = 1'b1;
                        st   = ST_NOT_WAVE;
                    end
                    else if (header_past_end(nxt))
                    begin
                        emit = 1'b1;
                        st   = ST_NO_DATA;
                    end
                end
            end
            PH_CHUNK_HEAD:
            begin
                used = 32'd8 - remain_q;
                // tag bytes arrive first, then the size little endian
                if (used[2:0] < 3'd4)
                    tag_q = {tag_q[23:0], b};
                else
                    size_q = {b, size_q[31:8]};
                remain_q = (remain_q - 32'd1) & 32'd7;
                if (remain_q == 32'd0)
                begin
                    if (tag_q == TAG_DATA)
                    begin
                        emit    = 1'b1;
                        st      = ST_OK;
                        out_off = nxt[31:0];
                        out_len = size_q;
                    end
                    else if (!is_printable_tag(tag_q) ||
                             nxt + {32'd0, size_q} > {32'd0, file_len_q})
                    begin
                        emit = 1'b1;
                        st   = ST_BAD_CHUNK;
                    end
                    else if (tag_q == TAG_FMT && size_q < FMT_BYTES)
                    begin
                        emit = 1'b1;
                        st   = ST_FMT_ERR;
                    end
                    else
                    begin
                        padded = {32'd0, size_q} + {63'd0, size_q[0]};
                        if (tag_q == TAG_FACT)
                            fact_q = '0;
                        if (padded == 64'd0 || padded > 64'hFFFF_FFFF)
                        begin
                            if (header_past_end(nxt + padded))
                            begin
                                emit = 1'b1;
                                st   = ST_NO_DATA;
                            end
                        end
                        else
                        begin
                            remain_q = padded[31:0];
                            phase_q  = PH_CHUNK_BODY;
                        end
                    end
                end
            end
            PH_CHUNK_BODY:
            begin
                padded32 = size_q + {31'd0, size_q[0]};
                off      = padded32 - remain_q;
                // the pad byte after an odd size carries nothing
                if (off < size_q)
                begin
                    if (tag_q == TAG_FMT && off < FMT_BYTES)
                    begin
                        if (off[3])
                            fmt_hi[8*off[2:0] +: 8] = b;
                        else
                            fmt_lo[8*off[2:0] +: 8] = b;
                    end
                    else if (tag_q == TAG_FACT && off < 32'd4)
                        fact_q = fact_q | ({24'd0, b} << (8 * off[1:0]));
                end
                remain_q = remain_q - 32'd1;
                if (remain_q == 32'd0 && header_past_end(nxt))
                begin
                    emit = 1'b1;
                    st   = ST_NO_DATA;
                end
            end
            default:
            begin
                parse_done = 1'b1;
            end
        endcase
        if (emit)
        begin
            parse_done      = 1'b1;
            s.status        = st;
            s.data_offset   = out_off;
            s.data_length   = out_len;
            s.sample_length = fact_q;
            s.format_tag    = fmt_lo[15:0];
            s.channel_count = fmt_lo[31:16];
            s.sample_rate   = fmt_lo[63:32];
            s.byte_rate     = fmt_hi[31:0];
            s.block_align   = fmt_hi[47:32];
            s.sample_bits   = fmt_hi[63:48];
            summary_queue.push_back(s);
        end
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            file_len_q = '0;
            restart_parser();
            summary_queue.delete();
            mismatches = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == LEN_ADDR)
                file_len_q = pwdata;
            if (result_valid && result_ready)
            begin
                if (summary_queue.size() == 0)
                begin
                    $error("status %0d result arrived with nothing predicted", status);
                    mismatches++;
                end
                else
                begin
                    oldest = summary_queue.pop_front();
                    compare_field("status", oldest.status, status);
                    compare_field("data_offset", oldest.data_offset, data_offset);
                    compare_field("data_length", oldest.data_length, data_length);
                    compare_field("sample_length", oldest.sample_length, sample_length);
                    compare_field("format_tag", oldest.format_tag, format_tag);
                    compare_field("channel_count", oldest.channel_count, channel_count);
                    compare_field("sample_rate", oldest.sample_rate, sample_rate);
                    compare_field("byte_rate", oldest.byte_rate, byte_rate);
                    compare_field("block_align", oldest.block_align, block_align);
                    compare_field("sample_bits", oldest.sample_bits, sample_bits);
                end
            end
            if (item_valid && item_ready)
                advance_parser(byte_value, start_req);
        end
        mismatch_count    <= mismatches;
        summaries_pending <= summary_queue.size();
    end

endmodule

>>> verif/wave_header_chunk_parser_top_test.sv
// testbench top for the riff/wave header parser: clock, reset, file stimulus and verdict
module wave_header_chunk_parser_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import wavhdr_pkg::*;

    localparam int IDLE_LIMIT      = 2000;
    localparam int RANDOM_ITEMS    = 1000;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int SETTLE_CYCLES   = 4;
    localparam logic [ADDR_W-1:0] LEN_ADDR = {REG_FILE_LENGTH, 2'b00};

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              item_valid;
    logic              item_ready;
    logic [7:0]        byte_value;
    logic              start_req;
    logic              result_valid;
    logic              result_ready;
    logic [2:0]        status;
    logic [31:0]       data_offset;
    logic [31:0]       data_length;
    logic [31:0]       sample_length;
    logic [15:0]       format_tag;
    logic [15:0]       channel_count;
    logic [31:0]       sample_rate;
    logic [31:0]       byte_rate;
    logic [15:0]       block_align;
    logic [15:0]       sample_bits;

    int mismatch_count;
    int summaries_pending;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int items_sent     = 0;
    int idle_cycles    = 0;

    logic [7:0] file_bytes[$];

    wave_header_chunk_parser_top u_top (.*);

    wave_header_chunk_parser_checker u_checker (.*);

    always #1ns clk = ~clk;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else
            result_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // watchdog: no request or result moving for too long
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL wave_header_chunk_parser_top");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic set_idle_mode(input idle_mode_t mode);
        case (mode)
            IDLE_NONE:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            IDLE_SENDER:
            begin
                send_idle_pct  = 69;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 69;
            end
            default:
            begin
                send_idle_pct  = 12;
                recv_stall_pct = 12;
            end
        endcase
    endtask

    task automatic send_byte(input logic [7:0] value, input logic first);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        byte_value <= value;
        start_req  <= first;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic wait_for_results();
        item_valid <= 1'b0;
        @(posedge clk);
        while (summaries_pending != 0)
            @(posedge clk);
        // bytes that give no result may still be in flight
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_file_length(input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LEN_ADDR;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic push_tag(input logic [31:0] t);
        file_bytes.push_back(t[31:24]);
        file_bytes.push_back(t[23:16]);
        file_bytes.push_back(t[15:8]);
        file_bytes.push_back(t[7:0]);
    endtask

    task automatic push_le(input logic [31:0] v);
        file_bytes.push_back(v[7:0]);
        file_bytes.push_back(v[15:8]);
        file_bytes.push_back(v[23:16]);
        file_bytes.push_back(v[31:24]);
    endtask

    task automatic push_noise(input int count);
        repeat (count) file_bytes.push_back($urandom_range(0, 255));
    endtask

    function automatic logic [31:0] random_tag();
        logic [31:0] t;
        for (int lane = 0; lane < 4; lane++)
            t[8*lane +: 8] = $urandom_range(32, 126);
        return t;
    endfunction

    // chunk with its body and the pad byte after an odd size
    task automatic push_chunk(input logic [31:0] tag, input logic [31:0] size);
        int fill;
        push_tag(tag);
        push_le(size);
        fill = $urandom_range(0, 9);
        for (logic [31:0] k = 0; k < size; k++)
        begin
            if (fill == 0)
                file_bytes.push_back(8'h00);
            else if (fill == 1)
                file_bytes.push_back(8'hFF);
            else
                file_bytes.push_back($urandom_range(0, 255));
        end
        if (size[0])
            file_bytes.push_back($urandom_range(0, 255));
    endtask

    task automatic build_file(input logic [31:0] flen);
        int          choice;
        int          kind;
        int          lane;
        logic [31:0] size;
        logic [31:0] tag;
        logic [31:0] p;
        file_bytes.delete();
        choice = $urandom_range(0, 99);
        if (flen < MIN_FILE)
        begin
            push_noise($urandom_range(1, 3));
            return;
        end
        if (choice >= 97)
        begin
            push_noise($urandom_range(1, 20));
            return;
        end
        if (choice < 4)
            push_tag(TAG_RIFF ^ (32'd1 << $urandom_range(0, 31)));
        else
            push_tag(TAG_RIFF);
        push_le($urandom);
        if (choice >= 4 && choice < 8)
            push_tag(TAG_WAVE ^ (32'd1 << $urandom_range(0, 31)));
        else
            push_tag(TAG_WAVE);
        repeat ($urandom_range(0, 3))
        begin
            kind = $urandom_range(0, 2);
            if (kind == 0)
            begin
                tag  = TAG_FMT;
                size = ($urandom_range(0, 3) == 0) ? FMT_BYTES + $urandom_range(1, 5) : FMT_BYTES;
            end
            else if (kind == 1)
            begin
                tag  = TAG_FACT;
                size = $urandom_range(0, 6);
            end
            else
            begin
                tag  = random_tag();
                size = $urandom_range(0, 9);
            end
            push_chunk(tag, size);
        end
        p = file_bytes.size();
        if (choice >= 8 && choice < 14)
        begin
            push_tag(TAG_FMT);
            push_le($urandom_range(0, FMT_BYTES - 1));
            return;
        end
        if (choice >= 14 && choice < 20)
        begin
            tag  = random_tag();
            lane = $urandom_range(0, 3);
            if ($urandom_range(0, 1) == 0)
                tag[8*lane +: 8] = $urandom_range(0, 31);
            else
                tag[8*lane +: 8] = $urandom_range(127, 255);
            push_tag(tag);
            push_le($urandom_range(0, 8));
            return;
        end
        if (choice >= 20 && choice < 26)
        begin
            push_tag(($urandom_range(0, 1) == 0) ? TAG_FMT : random_tag());
            push_le(flen - p - 32'd8 + $urandom_range(1, 64));
            return;
        end
        // filler that leaves no room for another chunk header
        if (choice >= 26 && choice < 34 && flen > p + 32'd16 && flen - p < 32'd400)
        begin
            push_chunk(random_tag(), flen - p - 32'd8 - $urandom_range(0, 8));
            return;
        end
        push_tag(TAG_DATA);
        if (choice >= 34 && choice < 37)
            size = '0;
        else if (choice >= 37 && choice < 40)
            size = '1;
        else if ($urandom_range(0, 1) == 0)
            size = $urandom;
        else
            size = $urandom_range(0, 4096);
        push_le(size);
        push_noise($urandom_range(0, 2));
    endtask

    task automatic send_file(input bit allow_break);
        int last;
        last = file_bytes.size();
        if (allow_break && $urandom_range(0, 9) == 0)
            send_byte($urandom_range(0, 255), 1'b0);
        if (allow_break && $urandom_range(0, 99) < 5)
            last = $urandom_range(1, file_bytes.size());
        for (int i = 0; i < last; i++)
            send_byte(file_bytes[i], i == 0);
    endtask

    function automatic logic [31:0] pick_file_length(input int ph);
        case (ph % 8)
            0:       return 32'hFFFF_FFFF;
            1:       return $urandom_range(44, 120);
            2:       return MIN_FILE;
            3:       return $urandom_range(121, 400);
            4:       return $urandom;
            5:       return $urandom_range(0, 43);
            6:       return 32'd1000;
            default: return $urandom_range(60, 300);
        endcase
    endfunction

    initial
    begin
        int          ph;
        int          phase_start;
        logic [31:0] flen;
        rst_n      <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        item_valid <= 1'b0;
        byte_value <= '0;
        start_req  <= 1'b0;
        set_idle_mode(IDLE_NONE);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no start_req after reset and file_length still zero, then ignored bytes
        send_byte(8'h52, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        wait_for_results();
        write_file_length(MIN_FILE - 32'd1);
        send_byte(8'h00, 1'b1);
        wait_for_results();
        write_file_length('1);
        file_bytes.delete();
        push_tag(32'h5249_4658);
        send_file(1'b0);
        file_bytes.delete();
        push_tag(TAG_RIFF);
        push_le('1);
        push_tag(32'h5741_5646);
        send_file(1'b0);
        // shortest good file: data header right after the wave tag
        file_bytes.delete();
        push_tag(TAG_RIFF);
        push_le('0);
        push_tag(TAG_WAVE);
        push_tag(TAG_DATA);
        push_le('1);
        send_file(1'b0);

        items_sent = 0;
        ph = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            flen = pick_file_length(ph);
            wait_for_results();
            write_file_length(flen);
            set_idle_mode(idle_mode_t'(ph % 4));
            phase_start = items_sent;
            while (items_sent - phase_start < ITEMS_PER_PHASE)
            begin
                build_file(flen);
                send_file(1'b1);
            end
            ph++;
        end
        wait_for_results();

        if (mismatch_count == 0)
            $display("PASS wave_header_chunk_parser_top");
        else
            $display("FAIL wave_header_chunk_parser_top");
        $finish;
    end

endmodule
